>>> hdl/framebuffer_pixel_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the framebuffer pixel engine
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_PIXEL_ENGINE_ASSERT_SVH
`define FRAMEBUFFER_PIXEL_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

`define FPE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define FPE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define FPE_ASSERT_IMP(lbl, ante, cons)

`define FPE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> hdl/fpe_pkg.sv
// ----------------------------------------------------------------------------
// fpe_pkg
// Shared types and constants of the framebuffer pixel engine.
// ----------------------------------------------------------------------------
package fpe_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int CFG_W   = 9;
  localparam int COORD_W = 12;
  localparam int PIX_W   = 32;

  localparam int MAC_A_W = 12;
  localparam int MAC_B_W = 9;
  localparam int MAC_R_W = 22;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_BLEND = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_GLYPH = 2'd3;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [7:0] ALPHA_MAX = 8'hFF;

  typedef struct packed {
    logic               go;
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
    logic [MAC_R_W-1:0] c;
  } mac_req_t;

endpackage

>>> hdl/fpe_ram.sv
// ----------------------------------------------------------------------------
// fpe_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/fpe_mac.sv
// ----------------------------------------------------------------------------
// fpe_mac
// Shared multiply-add unit: registers a*b+c on each request.
// ----------------------------------------------------------------------------
module fpe_mac import fpe_pkg::*; (
  input  logic               clk,
  input  mac_req_t           req,
  output logic [MAC_R_W-1:0] res
);

  logic [MAC_R_W-1:0] prod;
  logic [MAC_R_W-1:0] acc_r;
  logic [MAC_R_W-1:0] acc_nxt;

  assign prod    = MAC_R_W'(req.a) * MAC_R_W'(req.b);
  assign acc_nxt = prod + req.c;

  always_ff @(posedge clk) begin
    if (req.go) begin
      acc_r <= acc_nxt;
    end
  end

  assign res = acc_r;

endmodule

>>> hdl/framebuffer_pixel_engine.sv
// ----------------------------------------------------------------------------
// framebuffer_pixel_engine
// Pixel writer over a 32-bit ARGB frame store: put, blend, read, glyph row.
// ----------------------------------------------------------------------------
// Put and a clipped blend or read pass from accept through S_PIX to S_DONE,
// which raises the strobe; read adds S_RD, blend S_RD and S_MIX; a glyph row
// stays in S_PIX for eight pixels. The next request is taken after S_DONE.
// Blend runs six passes through the one multiply-add unit; glyph rows take
// one pixel per cycle on the single store port. After reset the store is
// cleared, busy high; config writes taken throughout. The receiver cannot stall.
// ----------------------------------------------------------------------------
`include "framebuffer_pixel_engine_assert.svh"

module framebuffer_pixel_engine import fpe_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_cmd,
  input  logic signed [COORD_W-1:0] in_x_pos,
  input  logic signed [COORD_W-1:0] in_y_pos,
  input  logic [PIX_W-1:0]          in_color,
  input  logic [7:0]                in_alpha,
  input  logic [7:0]                in_glyph_bits,
  output logic                      out_strobe,
  output logic [PIX_W-1:0]          out_read_data,
  output logic [3:0]                out_pixels_written,
  output logic                      out_clipped,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_PIX   = 6'b000100,
    S_RD    = 6'b001000,
    S_MIX   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [1:0]          cmd_r, cmd_nxt;
  logic [COORD_W-1:0]  x_r, x_nxt;
  logic [COORD_W-1:0]  y_r, y_nxt;
  logic [PIX_W-1:0]    color_r, color_nxt;
  logic [7:0]          alpha_r, alpha_nxt;
  logic [7:0]          bits_r, bits_nxt;
  logic [2:0]          j_r, j_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [PIX_W-1:0]    bg_r, bg_nxt;
  logic [15:0]         res_r, res_nxt;
  logic [PIX_W-1:0]    rd_r, rd_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  logic                clip_r, clip_nxt;
  logic [CFG_W-1:0]    width_r, width_nxt;
  logic [CFG_W-1:0]    height_r, height_nxt;

  logic [CFG_W-1:0]    eff_w;
  logic [CFG_W-1:0]    eff_h;
  logic [COORD_W:0]    xj;
  logic                x_in;
  logic                y_in;
  logic                pix_in;
  logic                bit_sel;
  logic [MAC_R_W-1:0]  pix_sum;
  logic [AW-1:0]       pix_addr;
  logic [1:0]          ch;
  logic [7:0]          fg_byte;
  logic [7:0]          bg_byte;

  mac_req_t            mac_req;
  logic [MAC_R_W-1:0]  mac_res;

  logic                ram_en;
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [PIX_W-1:0]    ram_wdata;
  logic [PIX_W-1:0]    ram_rdata;

  logic                cfg_wr;

  fpe_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .res (mac_res)
  );

  fpe_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {{(32-CFG_W){1'b0}}, (paddr[2] == REG_HEIGHT) ? height_r : width_r};

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        width_nxt = pwdata[CFG_W-1:0];
      end else begin
        height_nxt = pwdata[CFG_W-1:0];
      end
    end
  end

  // Clipping and addressing
  assign eff_w = (int'(width_r) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : width_r;
  assign eff_h = (int'(height_r) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : height_r;

  assign xj      = {x_r[COORD_W-1], x_r} + (COORD_W+1)'(j_r);
  assign x_in    = !xj[COORD_W] && (xj[COORD_W-1:0] < COORD_W'(eff_w));
  assign y_in    = !y_r[COORD_W-1] && (y_r < COORD_W'(eff_h));
  assign pix_in  = x_in && y_in;
  assign bit_sel = (cmd_r == CMD_GLYPH) ? bits_r[3'd7 - j_r] : 1'b1;
  assign pix_sum = mac_res + MAC_R_W'(xj[COORD_W-1:0]);
  assign pix_addr = AW'(pix_sum);

  // Channel select for blend
  assign ch = step_r[2:1];

  always_comb begin
    unique case (ch)
      2'd0: begin
        fg_byte = color_r[23:16];
        bg_byte = bg_r[23:16];
      end
      2'd1: begin
        fg_byte = color_r[15:8];
        bg_byte = bg_r[15:8];
      end
      2'd2: begin
        fg_byte = color_r[7:0];
        bg_byte = bg_r[7:0];
      end
      default: begin
        fg_byte = 8'h00;
        bg_byte = 8'h00;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cmd_nxt   = cmd_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    color_nxt = color_r;
    alpha_nxt = alpha_r;
    bits_nxt  = bits_r;
    j_nxt     = j_r;
    step_nxt  = step_r;
    addr_nxt  = addr_r;
    bg_nxt    = bg_r;
    res_nxt   = res_r;
    rd_nxt    = rd_r;
    cnt_nxt   = cnt_r;
    clip_nxt  = clip_r;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = pix_addr;
    ram_wdata = color_r;
    mac_req   = '0;

    unique case (state_r)
      S_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt     = in_cmd;
          x_nxt       = in_x_pos;
          y_nxt       = in_y_pos;
          color_nxt   = in_color;
          alpha_nxt   = in_alpha;
          bits_nxt    = in_glyph_bits;
          j_nxt       = '0;
          step_nxt    = '0;
          rd_nxt      = '0;
          cnt_nxt     = '0;
          clip_nxt    = 1'b0;
          // row base y*W
          mac_req.go  = 1'b1;
          mac_req.a   = in_y_pos;
          mac_req.b   = eff_w;
          mac_req.c   = '0;
          state_nxt   = S_PIX;
        end
      end
      S_PIX: begin
        if (bit_sel) begin
          if (pix_in) begin
            ram_en   = 1'b1;
            addr_nxt = pix_addr;
            if (cmd_r == CMD_PUT || cmd_r == CMD_GLYPH) begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
          end else begin
            clip_nxt = 1'b1;
          end
        end
        priority if (cmd_r == CMD_GLYPH) begin
          j_nxt = j_r + 1'b1;
          if (j_r == 3'd7) begin
            state_nxt = S_DONE;
          end
        end else if ((cmd_r == CMD_READ || cmd_r == CMD_BLEND) && pix_in) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RD: begin
        if (cmd_r == CMD_READ) begin
          rd_nxt    = ram_rdata;
          state_nxt = S_DONE;
        end else begin
          bg_nxt    = ram_rdata;
          step_nxt  = '0;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        step_nxt = step_r + 1'b1;
        if (step_r != 3'd0 && !step_r[0]) begin
          res_nxt = {res_r[7:0], mac_res[15:8]};
        end
        if (step_r == 3'd6) begin
          ram_en    = 1'b1;
          ram_we    = 1'b1;
          ram_addr  = addr_r;
          ram_wdata = {ALPHA_MAX, res_r, mac_res[15:8]};
          cnt_nxt   = 4'd1;
          state_nxt = S_DONE;
        end else if (!step_r[0]) begin
          mac_req.go = 1'b1;
          mac_req.a  = MAC_A_W'(fg_byte);
          mac_req.b  = MAC_B_W'(alpha_r);
          mac_req.c  = '0;
        end else begin
          mac_req.go = 1'b1;
          mac_req.a  = MAC_A_W'(bg_byte);
          mac_req.b  = MAC_B_W'(ALPHA_MAX - alpha_r);
          mac_req.c  = mac_res;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      width_r  <= CFG_RESET;
      height_r <= CFG_RESET;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    color_r <= color_nxt;
    alpha_r <= alpha_nxt;
    bits_r  <= bits_nxt;
    j_r     <= j_nxt;
    step_r  <= step_nxt;
    addr_r  <= addr_nxt;
    bg_r    <= bg_nxt;
    res_r   <= res_nxt;
    rd_r    <= rd_nxt;
    cnt_r   <= cnt_nxt;
    clip_r  <= clip_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_strobe         = (state_r == S_DONE);
  assign out_read_data      = rd_r;
  assign out_pixels_written = cnt_r;
  assign out_clipped        = clip_r;

  `FPE_ASSERT_NXT(a_strobe_single, out_strobe, !out_strobe)
  `FPE_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `FPE_ASSERT_IMP(a_data_read_only, out_strobe && cmd_r != CMD_READ, out_read_data == '0)
  `FPE_ASSERT_IMP(a_read_no_write, out_strobe && cmd_r == CMD_READ, out_pixels_written == 4'd0)
  `FPE_ASSERT_IMP(a_count_range, out_strobe, out_pixels_written <= 4'd8)

endmodule

>>> tb/sv/tb_framebuffer_pixel_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framebuffer_pixel_engine
// Self-checking bench for the pixel engine. It keeps a shadow copy of the
// frame store and the screen registers, predicts every result from it, and
// runs directed edge cases and then randomized traffic over several screen
// sizes, with random idle gaps on the request side.
// ----------------------------------------------------------------------------
module tb_framebuffer_pixel_engine;
  import fpe_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 12;
  localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic [PIX_W-1:0]   color;
    logic [7:0]         alpha;
    logic [7:0]         glyph_bits;
  } pixel_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] read_data;
    logic [3:0]       pixels_written;
    logic             clipped;
  } pixel_res_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [1:0]                in_cmd;
  logic signed [COORD_W-1:0] in_x_pos;
  logic signed [COORD_W-1:0] in_y_pos;
  logic [PIX_W-1:0]          in_color;
  logic [7:0]                in_alpha;
  logic [7:0]                in_glyph_bits;
  logic                      out_strobe;
  logic [PIX_W-1:0]          out_read_data;
  logic [3:0]                out_pixels_written;
  logic                      out_clipped;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [2:0]                paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  bit [PIX_W-1:0] shadow_fb [0:STORE_DEPTH-1];
  logic [CFG_W-1:0] screen_w_reg;
  logic [CFG_W-1:0] screen_h_reg;
  pixel_res_t expected_results [$];
  int fail_count;
  bit idle_enable;

  framebuffer_pixel_engine u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_x_pos           (in_x_pos),
    .in_y_pos           (in_y_pos),
    .in_color           (in_color),
    .in_alpha           (in_alpha),
    .in_glyph_bits      (in_glyph_bits),
    .out_strobe         (out_strobe),
    .out_read_data      (out_read_data),
    .out_pixels_written (out_pixels_written),
    .out_clipped        (out_clipped),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #5 clk = ~clk;

  function automatic int visible_width();
    return (int'(screen_w_reg) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(screen_w_reg);
  endfunction

  function automatic int visible_height();
    return (int'(screen_h_reg) > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(screen_h_reg);
  endfunction

  function automatic bit pixel_index(input int px, input int py, output int idx);
    int w;
    int h;
    w = visible_width();
    h = visible_height();
    idx = 0;
    if (px < 0 || py < 0 || px >= w || py >= h) return 1'b0;
    idx = py * w + px;
    return 1'b1;
  endfunction

  function automatic logic [7:0] mix_channel(input int fg, input int bg, input int a);
    int sum;
    sum = (fg * a + bg * (255 - a)) >> 8;
    return sum[7:0];
  endfunction

  function automatic pixel_res_t render_pixel_op(input pixel_req_t req);
    pixel_res_t res;
    int px;
    int py;
    int idx;
    logic [PIX_W-1:0] bg;
    res = '0;
    px = int'($signed(req.x_pos));
    py = int'($signed(req.y_pos));
    case (req.cmd)
      CMD_PUT: begin
        if (pixel_index(px, py, idx)) begin
          shadow_fb[idx] = req.color;
          res.pixels_written = 4'd1;
        end else res.clipped = 1'b1;
      end
      CMD_BLEND: begin
        if (pixel_index(px, py, idx)) begin
          bg = shadow_fb[idx];
          shadow_fb[idx] = {ALPHA_MAX,
            mix_channel(req.color[23:16], bg[23:16], req.alpha),
            mix_channel(req.color[15:8], bg[15:8], req.alpha),
            mix_channel(req.color[7:0], bg[7:0], req.alpha)};
          res.pixels_written = 4'd1;
        end else res.clipped = 1'b1;
      end
      CMD_READ: begin
        if (pixel_index(px, py, idx)) res.read_data = shadow_fb[idx];
        else res.clipped = 1'b1;
      end
      default: begin
        for (int j = 0; j < 8; j++) begin
          if (req.glyph_bits[7-j]) begin
            if (pixel_index(px + j, py, idx)) begin
              shadow_fb[idx] = req.color;
              res.pixels_written = res.pixels_written + 4'd1;
            end else res.clipped = 1'b1;
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic pixel_req_t make_req(input logic [1:0] cmd, input int px, input int py,
                                          input logic [31:0] color, input logic [7:0] alpha,
                                          input logic [7:0] glyph_bits);
    pixel_req_t req;
    req.cmd = cmd;
    req.x_pos = px[COORD_W-1:0];
    req.y_pos = py[COORD_W-1:0];
    req.color = color;
    req.alpha = alpha;
    req.glyph_bits = glyph_bits;
    return req;
  endfunction

  function automatic int pick_coord(input int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, (lim > 0) ? lim - 1 : 0);
    if (r < 90) return int'($urandom_range(0, lim + 16)) - 8;
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  task automatic send_request(input pixel_req_t req);
    if (idle_enable && $urandom_range(0, 99) < 13) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
    @(negedge clk);
    in_cmd = req.cmd;
    in_x_pos = req.x_pos;
    in_y_pos = req.y_pos;
    in_color = req.color;
    in_alpha = req.alpha;
    in_glyph_bits = req.glyph_bits;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    expected_results.push_back(render_pixel_op(req));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
  endtask

  task automatic write_screen_reg(input logic reg_sel, input logic [CFG_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_sel, 2'b00};
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_WIDTH) screen_w_reg = value;
    else screen_h_reg = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic test_directed_edges();
    send_request(make_req(CMD_READ, 0, 0, 32'h0, 8'h0, 8'h0));
    send_request(make_req(CMD_PUT, 0, 0, 32'hFFFF_FFFF, 8'h0, 8'h0));
    send_request(make_req(CMD_PUT, 255, 255, 32'h1234_5678, 8'h0, 8'h0));
    send_request(make_req(CMD_READ, 255, 255, 32'h0, 8'h0, 8'h0));
    send_request(make_req(CMD_PUT, 256, 0, 32'hDEAD_BEEF, 8'h0, 8'h0));
    send_request(make_req(CMD_PUT, -1, 5, 32'hDEAD_BEEF, 8'h0, 8'h0));
    send_request(make_req(CMD_READ, 2047, -2048, 32'h0, 8'h0, 8'h0));
    send_request(make_req(CMD_PUT, 10, 2047, 32'h0000_00FF, 8'h0, 8'h0));
    send_request(make_req(CMD_BLEND, 0, 0, 32'hA0FF_8000, 8'h00, 8'h0));
    send_request(make_req(CMD_BLEND, 1, 0, 32'h00FF_FFFF, ALPHA_MAX, 8'h0));
    send_request(make_req(CMD_BLEND, 255, 255, 32'h7F00_FF80, 8'h80, 8'h0));
    send_request(make_req(CMD_BLEND, -2048, 0, 32'hFFFF_FFFF, 8'h80, 8'h0));
    send_request(make_req(CMD_READ, 0, 0, 32'h0, 8'h0, 8'h0));
    send_request(make_req(CMD_READ, 1, 0, 32'h0, 8'h0, 8'h0));
    send_request(make_req(CMD_READ, 255, 255, 32'h0, 8'h0, 8'h0));
    send_request(make_req(CMD_GLYPH, 0, 1, 32'h5555_AAAA, 8'h0, 8'h00));
    send_request(make_req(CMD_GLYPH, 252, 1, 32'hC0FF_EE00, 8'h0, 8'hFF));
    send_request(make_req(CMD_GLYPH, -7, 2, 32'h0102_0304, 8'h0, 8'h81));
    send_request(make_req(CMD_GLYPH, -2048, -2048, 32'hFFFF_FFFF, 8'h0, 8'hFF));
    send_request(make_req(CMD_GLYPH, 2047, 2047, 32'hFFFF_FFFF, 8'h0, 8'hAA));
    send_request(make_req(CMD_READ, 255, 1, 32'h0, 8'h0, 8'h0));
    send_request(make_req(CMD_READ, 0, 2, 32'h0, 8'h0, 8'h0));
    send_request(make_req(CMD_BLEND, 0, 0, 32'h0000_0000, ALPHA_MAX, 8'h0));
    send_request(make_req(CMD_READ, 0, 0, 32'h0, 8'h0, 8'h0));
    wait_idle();
  endtask

  task automatic run_random_requests(input int count);
    int w;
    int h;
    logic [7:0] alpha;
    int r;
    w = visible_width();
    h = visible_height();
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 9);
      alpha = (r == 0) ? 8'h00 : (r == 1) ? ALPHA_MAX : 8'($urandom_range(0, 255));
      send_request(make_req(2'($urandom_range(0, 3)), pick_coord(w), pick_coord(h),
                            $urandom(), alpha, 8'($urandom_range(0, 255))));
    end
    wait_idle();
  endtask

  task automatic test_screen_sizes();
    int widths [10] = '{256, 511, 1, 17, 0, 256, 200, 9, 0, 0};
    int heights [10] = '{256, 511, 1, 9, 256, 0, 100, 300, 0, 0};
    int counts [10] = '{110, 110, 60, 110, 25, 25, 110, 110, 110, 15};
    widths[8] = $urandom_range(1, 511);
    heights[8] = $urandom_range(1, 511);
    for (int p = 0; p < 10; p++) begin
      idle_enable = (p != 6);
      write_screen_reg(REG_WIDTH, widths[p][CFG_W-1:0]);
      write_screen_reg(REG_HEIGHT, heights[p][CFG_W-1:0]);
      run_random_requests(counts[p]);
    end
    idle_enable = 1'b1;
  endtask

  always @(posedge clk) begin : check_results
    pixel_res_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: read_data %h pixels_written %0d clipped %0b",
               out_read_data, out_pixels_written, out_clipped);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_read_data);
          fail_count++;
        end
        if (out_pixels_written !== want.pixels_written) begin
          $error("pixels_written: expected %0d, got %0d", want.pixels_written,
                 out_pixels_written);
          fail_count++;
        end
        if (out_clipped !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, out_clipped);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_framebuffer_pixel_engine failed");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_PUT;
    in_x_pos = '0;
    in_y_pos = '0;
    in_color = '0;
    in_alpha = '0;
    in_glyph_bits = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    screen_w_reg = CFG_RESET;
    screen_h_reg = CFG_RESET;
    fail_count = 0;
    idle_enable = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges();
    test_screen_sizes();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) $display("tb_framebuffer_pixel_engine passed");
    else $display("tb_framebuffer_pixel_engine failed");
    $finish;
  end

endmodule
